// ===== hw/rtl/grw_pkg.sv =====
// ----------------------------------------------------------------------------
// grw_pkg: shared types for the Givens rotation wavefront
// Transfer payload structures and the sequencer state encoding.
// ----------------------------------------------------------------------------
package grw_pkg;

    localparam int unsigned ElemWidth = 32;

    typedef struct packed {
        logic               action;
        logic [5:0]         coef_slot;
        logic signed [31:0] cos_value;
        logic signed [31:0] sin_value;
        logic [3:0]         col_index;
        logic signed [31:0] element_value;
        logic               last_row;
    } t_in;

    typedef struct packed {
        logic [3:0]         out_col;
        logic signed [31:0] out_value;
        logic               row_end;
        logic               block_end;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PASS,
        S_WAIT,
        S_EMIT
    } t_state;

    localparam logic ActLoad    = 1'b0;
    localparam logic ActElement = 1'b1;

endpackage

// ===== hw/rtl/givens_rotation_wave.sv =====
// ----------------------------------------------------------------------------
// givens_rotation_wave: wavefront of Givens rotations over a matrix row
// Loads cosine/sine pairs into slots, buffers one row and rotates it.
// ----------------------------------------------------------------------------
// A coefficient load, or a row element other than the last column, is only
// stored. The last column starts the wavefront: after a start state, each of
// the WAVE_DEPTH waves is one pass of 2*WAVE_DEPTH shifts around the chain of
// column cells. A plain shift is done directly; a rotation is issued and the
// shift waits for the two stages of the rotation unit, the second of which
// registers the pair. After the last wave the results are offered, one result
// per cycle while the output is not stalled. The input is stalled until the
// last result of the row has been transferred. The rotations are serial
// because each takes the y output of the one before it.
module givens_rotation_wave
    import grw_pkg::*;
#(
    parameter int unsigned WAVE_DEPTH = 6,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int unsigned RowLen    = 2 * WAVE_DEPTH;
    localparam int unsigned SlotCount = WAVE_DEPTH * WAVE_DEPTH;
    localparam int unsigned SatBits   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int unsigned CellCount = RowLen - 1;
    localparam int unsigned IW = $clog2(RowLen);
    localparam int unsigned PW = $clog2(RowLen + 1);
    localparam int unsigned KW = $clog2(WAVE_DEPTH + 1);
    localparam int unsigned SW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

    t_state r_state;
    t_state n_state;
    logic [KW-1:0] r_wave;
    logic [KW-1:0] n_wave;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] n_slot;
    logic [IW-1:0] r_emit;
    logic [IW-1:0] n_emit;
    logic          r_last;
    logic          n_last;
    logic signed [ElemWidth-1:0] r_carry;
    logic signed [ElemWidth-1:0] n_carry;

    logic signed [ElemWidth-1:0] cos_mem [SlotCount];
    logic signed [ElemWidth-1:0] sin_mem [SlotCount];
    logic signed [ElemWidth-1:0] r_cos_q;
    logic signed [ElemWidth-1:0] r_sin_q;

    logic signed [ElemWidth-1:0] cell_q [CellCount];
    logic signed [ElemWidth-1:0] tail_data;
    logic                        shift;
    logic                        rot_start;
    logic                        rot_done;
    logic signed [ElemWidth-1:0] rot_x;
    logic signed [ElemWidth-1:0] rot_y;

    logic          in_xfer;
    logic          out_xfer;
    logic [IW+3:0] col_ext;
    logic [SW+5:0] slot_ext;
    logic          col_ok;
    logic          slot_ok;
    logic          elem_wr;
    logic [PW:0]   rot_lo;
    logic [PW:0]   rot_hi;
    logic          in_rot;
    logic          pass_end;
    logic          wave_end;
    logic [IW+3:0] emit_ext;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;
    assign col_ext  = (IW + 4)'(i_in_data.col_index);
    assign slot_ext = (SW + 6)'(i_in_data.coef_slot);
    assign col_ok   = col_ext < (IW + 4)'(RowLen);
    assign slot_ok  = slot_ext < (SW + 6)'(SlotCount);
    assign elem_wr  = in_xfer && (i_in_data.action == ActElement) && col_ok;

    assign rot_lo   = (PW + 1)'(WAVE_DEPTH) - (PW + 1)'(r_wave);
    assign rot_hi   = (PW + 1)'(RowLen - 1) - (PW + 1)'(r_wave);
    assign in_rot   = ((PW + 1)'(r_pos) >= rot_lo) && ((PW + 1)'(r_pos) <= rot_hi);
    assign pass_end = r_pos == PW'(RowLen);
    assign wave_end = r_wave == KW'(WAVE_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in_data.action == ActLoad) && slot_ok) begin
            cos_mem[i_in_data.coef_slot[SW-1:0]] <= i_in_data.cos_value;
            sin_mem[i_in_data.coef_slot[SW-1:0]] <= i_in_data.sin_value;
        end
        r_cos_q <= cos_mem[r_slot];
        r_sin_q <= sin_mem[r_slot];
    end

    genvar g;
    generate
        for (g = 0; g < CellCount; g++) begin : g_cell
            logic signed [ElemWidth-1:0] nb_data;
            if (g == CellCount - 1) begin : g_tail
                assign nb_data = tail_data;
            end else begin : g_mid
                assign nb_data = cell_q[g+1];
            end
            grw_cell u_cell (
                .i_clk        (i_clk),
                .i_shift      (shift),
                .i_shift_data (nb_data),
                .i_wr         (elem_wr && (col_ext == (IW + 4)'(g + 1))),
                .i_wr_data    (i_in_data.element_value),
                .o_data       (cell_q[g])
            );
        end
    endgenerate

    grw_rot #(
        .SAT_BITS (SatBits)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_c     (r_cos_q),
        .i_s     (r_sin_q),
        .i_x     (r_carry),
        .i_y     (cell_q[0]),
        .o_done  (rot_done),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wave  <= '0;
            r_pos   <= '0;
            r_slot  <= '0;
            r_emit  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wave  <= n_wave;
            r_pos   <= n_pos;
            r_slot  <= n_slot;
            r_emit  <= n_emit;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    always_comb begin
        n_state   = r_state;
        n_wave    = r_wave;
        n_pos     = r_pos;
        n_slot    = r_slot;
        n_emit    = r_emit;
        n_last    = r_last;
        n_carry   = r_carry;
        shift     = 1'b0;
        tail_data = r_carry;
        rot_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (elem_wr) begin
                    if (col_ext == '0) begin
                        n_carry = i_in_data.element_value;
                    end
                    if (col_ext == (IW + 4)'(RowLen - 1)) begin
                        n_last  = i_in_data.last_row;
                        n_wave  = '0;
                        n_pos   = PW'(1);
                        n_slot  = '0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_PASS;
            end
            S_PASS: begin
                if (in_rot) begin
                    rot_start = 1'b1;
                    n_slot    = r_slot + SW'(1);
                    n_state   = S_WAIT;
                end else begin
                    shift   = 1'b1;
                    n_carry = cell_q[0];
                    if (pass_end) begin
                        n_pos = PW'(1);
                        if (wave_end) begin
                            n_emit  = '0;
                            n_state = S_EMIT;
                        end else begin
                            n_wave = r_wave + KW'(1);
                        end
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            S_WAIT: begin
                if (rot_done) begin
                    shift     = 1'b1;
                    tail_data = rot_x;
                    n_carry   = rot_y;
                    n_pos     = r_pos + PW'(1);
                    n_state   = S_PASS;
                end
            end
            S_EMIT: begin
                if (out_xfer) begin
                    shift   = 1'b1;
                    n_carry = cell_q[0];
                    if (r_emit == IW'(RowLen - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_emit = r_emit + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign emit_ext = (IW + 4)'(r_emit);

    assign o_in_stall             = r_state != S_IDLE;
    assign o_out_valid            = r_state == S_EMIT;
    assign o_out_data.out_col     = emit_ext[3:0];
    assign o_out_data.out_value   = r_carry;
    assign o_out_data.row_end     = r_emit == IW'(RowLen - 1);
    assign o_out_data.block_end   = r_last;

`ifndef SYNTHESIS
    a_no_accept_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while results are pending");

    a_row_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_data.row_end) |=> !o_out_valid && !o_in_stall)
        else $error("block did not return to idle after the last result");

    a_last_col_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (elem_wr && (col_ext == (IW + 4)'(RowLen - 1))) |=> o_in_stall && !o_out_valid)
        else $error("wavefront did not start on the last column");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rot_done |-> (r_state == S_WAIT))
        else $error("rotation finished outside its wait state");
`endif

endmodule

// ===== hw/rtl/grw_cell.sv =====
// ----------------------------------------------------------------------------
// grw_cell: one element of the row chain
// Holds one column value, takes its neighbour's value on a shift or a
// direct write when a row element is stored.
// ----------------------------------------------------------------------------
module grw_cell
    import grw_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic signed [ElemWidth-1:0] i_shift_data,
    input  logic                        i_wr,
    input  logic signed [ElemWidth-1:0] i_wr_data,
    output logic signed [ElemWidth-1:0] o_data
);

    logic signed [ElemWidth-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_shift_data;
        end else if (i_wr) begin
            r_value <= i_wr_data;
        end
    end

    assign o_data = r_value;

endmodule

// ===== hw/rtl/grw_rot.sv =====
// ----------------------------------------------------------------------------
// grw_rot: plane rotation unit
// Four products in the first stage, rounding, sum and saturation in the
// second; o_done rises when the second stage has registered the results.
// ----------------------------------------------------------------------------
module grw_rot
    import grw_pkg::*;
#(
    parameter int unsigned SAT_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [ElemWidth-1:0] i_c,
    input  logic signed [ElemWidth-1:0] i_s,
    input  logic signed [ElemWidth-1:0] i_x,
    input  logic signed [ElemWidth-1:0] i_y,
    output logic                        o_done,
    output logic signed [ElemWidth-1:0] o_x,
    output logic signed [ElemWidth-1:0] o_y
);

    localparam logic signed [63:0] RoundHalf = 64'sd536870912;
    localparam logic signed [34:0] SatHi = 35'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [34:0] SatLo = -SatHi - 35'sd1;

    logic               r_v1;
    logic               r_v2;
    logic signed [63:0] r_cx;
    logic signed [63:0] r_sy;
    logic signed [63:0] r_cy;
    logic signed [63:0] r_sx;
    logic signed [ElemWidth-1:0] r_xo;
    logic signed [ElemWidth-1:0] r_yo;

    logic signed [63:0] rnd_cx;
    logic signed [63:0] rnd_sy;
    logic signed [63:0] rnd_cy;
    logic signed [63:0] rnd_sx;
    logic signed [34:0] sum_x;
    logic signed [34:0] sum_y;
    logic signed [34:0] sat_x;
    logic signed [34:0] sat_y;

    always_comb begin
        rnd_cx = (r_cx + RoundHalf) >>> 30;
        rnd_sy = (r_sy + RoundHalf) >>> 30;
        rnd_cy = (r_cy + RoundHalf) >>> 30;
        rnd_sx = (r_sx + RoundHalf) >>> 30;
        sum_x  = $signed({rnd_cx[33], rnd_cx[33:0]}) + $signed({rnd_sy[33], rnd_sy[33:0]});
        sum_y  = $signed({rnd_cy[33], rnd_cy[33:0]}) - $signed({rnd_sx[33], rnd_sx[33:0]});
        if (sum_x > SatHi) begin
            sat_x = SatHi;
        end else if (sum_x < SatLo) begin
            sat_x = SatLo;
        end else begin
            sat_x = sum_x;
        end
        if (sum_y > SatHi) begin
            sat_y = SatHi;
        end else if (sum_y < SatLo) begin
            sat_y = SatLo;
        end else begin
            sat_y = sum_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cx <= 64'(i_c) * 64'(i_x);
            r_sy <= 64'(i_s) * 64'(i_y);
            r_cy <= 64'(i_c) * 64'(i_y);
            r_sx <= 64'(i_s) * 64'(i_x);
        end
        if (r_v1) begin
            r_xo <= sat_x[ElemWidth-1:0];
            r_yo <= sat_y[ElemWidth-1:0];
        end
    end

    assign o_done = r_v2;
    assign o_x    = r_xo;
    assign o_y    = r_yo;

endmodule
